FILE: design/mrt_pkg.sv
// Package for the memory region table: sizes, payload and control types,
// sequencer states and the page rounding helpers.
// No dependencies; every other design file but mrt_ram imports it.
package mrt_pkg;

	// Number of region slots (supported range 2 to 31).
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W      = 32;
	localparam int SLOT_W      = 2 * ADDR_W;
	localparam int ENT_W       = 5;
	localparam int PAGE_BITS   = 12;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_CUT = 1'b1;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] region_start;
		logic [ADDR_W-1:0] region_length;
		logic [ADDR_W-1:0] cut_end;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [ENT_W-1:0]  entries_used;
		logic [ADDR_W-1:0] high_mark;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
	} slot_t;

	// Update of the slot occupancy map.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic             nz;
	} smap_upd_t;

	// Lowest free slot as seen by the occupancy map.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} smap_st_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_PREP,
		S_ADD_COMMIT,
		S_CUT_RD,
		S_CUT_RE,
		S_CUT_CLIP,
		S_CUT_DEC,
		S_CUT_RIGHT,
		S_CUT_NEXT,
		S_FINISH
	} state_t;

	// Which caller an insertion returns to.
	typedef enum logic [1:0] {
		PH_TOP,
		PH_LEFT,
		PH_RIGHT
	} phase_t;

	function automatic logic [ADDR_W-1:0] page_down(input logic [ADDR_W-1:0] v);
		page_down = {v[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
	endfunction

	function automatic logic [ADDR_W-1:0] page_up(input logic [ADDR_W-1:0] v);
		if (v[PAGE_BITS-1:0] == '0) begin
			page_up = v;
		end else begin
			page_up = {v[ADDR_W-1:PAGE_BITS] + (ADDR_W-PAGE_BITS)'(1), {PAGE_BITS{1'b0}}};
		end
	endfunction

endpackage

FILE: design/mrt_req_if.sv
// Request channel of the memory region table: valid, ready and payload.
// Depends on mrt_pkg.
interface mrt_req_if
	import mrt_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/mrt_rsp_if.sv
// Response channel of the memory region table: valid, ready and payload.
// Depends on mrt_pkg.
interface mrt_rsp_if
	import mrt_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/memory_region_table.sv
// Memory region table. An add request writes the rounded region into the lowest free slot; a cut
// walks every slot in use, clears each slot that it overlaps and inserts the remainders of that slot.
// One request is in flight at a time; the next is accepted once the sequencer is idle again,
// even while the previous response waits in the output register. Reset (arst_n, asynchronous)
// clears the slot count, high mark and occupancy map at once; the RAM needs no clearing pass.
module memory_region_table
	import mrt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mrt_req_if.sink    req,
	mrt_rsp_if.source  rsp
);
	// The slot table lives in one RAM holding {start, length} per slot. Every
	// slot below the slot count has been written before it can be read: a slot
	// only raises the count when it is written, and all slots below it were
	// occupied, hence written, at that moment. The cut walk reads only below the
	// count, and insertions pick slots from the occupancy map, so stale RAM
	// contents after reset are never observed.
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [SLOT_W-1:0] ram_wdata, ram_rdata;

	smap_upd_t smap_upd;
	smap_st_t  smap_st;

	logic seq_idle;
	logic seq_done;
	rsp_t seq_rsp;

	// Output register: holds a finished response while the sequencer goes on.
	logic rsp_valid_q;
	rsp_t rsp_data_q;
	logic rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = seq_idle;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			rsp_data_q <= seq_rsp;
		end
	end

	mrt_ram #(
		.Width(SLOT_W),
		.Depth(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The occupancy map answers the lowest free slot in the same cycle, so an
	// insertion commits in one step without scanning the RAM.
	mrt_smap u_smap (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (smap_upd),
		.st     (smap_st)
	);

	// The sequencer walks slots one RAM read at a time; a slot is written only
	// after its read data has been evaluated, so reads and writes never overlap.
	mrt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid && req.ready),
		.req_data  (req.data),
		.idle      (seq_idle),
		.rsp_free  (rsp_free),
		.done      (seq_done),
		.rsp_data  (seq_rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.smap_upd  (smap_upd),
		.smap_st   (smap_st)
	);
endmodule

FILE: design/mrt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mrt_ram #(
	parameter int Width = 64,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: design/mrt_smap.sv
// Slot occupancy map: one bit per slot, set when the slot holds a nonzero
// length, and a priority encoder giving the lowest free slot. Depends on mrt_pkg.
module mrt_smap
	import mrt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  smap_upd_t upd,
	output smap_st_t  st
);
	logic [MAX_ENTRIES-1:0] nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else if (upd.we) begin
			nz_q[upd.idx] <= upd.nz;
		end
	end

	// Scan from the top so that the lowest free slot wins.
	always_comb begin
		st = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!nz_q[i]) begin
				st.found = 1'b1;
				st.idx   = IDX_W'(i);
			end
		end
	end
endmodule

FILE: design/mrt_seq.sv
// Sequencer of the memory region table: runs an add as at most one slot
// write and a cut as a read-modify-write walk over the slot RAM. Depends on
// mrt_pkg, drives mrt_ram and mrt_smap through the top level.
module mrt_seq
	import mrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req_data,
	output logic              idle,
	input  logic              rsp_free,
	output logic              done,
	output rsp_t              rsp_data,
	output logic              ram_we,
	output logic [IDX_W-1:0]  ram_waddr,
	output logic [SLOT_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [IDX_W-1:0]  ram_raddr,
	input  logic [SLOT_W-1:0] ram_rdata,
	output smap_upd_t         smap_upd,
	input  smap_st_t          smap_st
);
	state_t            state_q, state_d;
	phase_t            phase_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] high_q;
	logic              full_q;

	logic [ADDR_W-1:0] lo_q, hi_q;
	logic [ADDR_W-1:0] pend_start_q, pend_len_q;
	logic [ADDR_W-1:0] s_q, l_q;
	logic [ADDR_W-1:0] rs_q, re_q, cs_q, ce_q;

	slot_t             rd_slot;
	logic [ADDR_W-1:0] new_end;
	state_t            ret_state;

	assign rd_slot  = slot_t'(ram_rdata);
	assign new_end  = s_q + l_q;
	assign idle     = (state_q == S_IDLE);

	assign rsp_data.status       = full_q ? STAT_FULL : STAT_OK;
	assign rsp_data.entries_used = ENT_W'(count_q);
	assign rsp_data.high_mark    = high_q;

	always_comb begin
		case (phase_q)
			PH_LEFT:  ret_state = S_CUT_RIGHT;
			PH_RIGHT: ret_state = S_CUT_NEXT;
			default:  ret_state = S_FINISH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q[IDX_W-1:0];
		smap_upd  = '0;
		done      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (req_data.opcode == OP_ADD) ? S_ADD_PREP : S_CUT_RD;
				end
			end
			S_ADD_PREP: begin
				state_d = (pend_len_q == '0) ? ret_state : S_ADD_COMMIT;
			end
			S_ADD_COMMIT: begin
				if (!smap_st.found) begin
					state_d = S_FINISH;
				end else begin
					ram_we       = 1'b1;
					ram_waddr    = smap_st.idx;
					ram_wdata    = {s_q, l_q};
					smap_upd.we  = 1'b1;
					smap_upd.idx = smap_st.idx;
					smap_upd.nz  = (l_q != '0);
					state_d      = ret_state;
				end
			end
			S_CUT_RD: begin
				if (idx_q < count_q) begin
					ram_re  = 1'b1;
					state_d = S_CUT_RE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_CUT_RE: begin
				state_d = S_CUT_CLIP;
			end
			S_CUT_CLIP: begin
				state_d = S_CUT_DEC;
			end
			S_CUT_DEC: begin
				if (cs_q >= ce_q) begin
					state_d = S_CUT_NEXT;
				end else begin
					ram_we       = 1'b1;
					smap_upd.we  = 1'b1;
					smap_upd.idx = idx_q[IDX_W-1:0];
					smap_upd.nz  = 1'b0;
					state_d      = (cs_q > rs_q) ? S_ADD_PREP : S_CUT_RIGHT;
				end
			end
			S_CUT_RIGHT: begin
				state_d = (ce_q < re_q) ? S_ADD_PREP : S_CUT_NEXT;
			end
			S_CUT_NEXT: begin
				state_d = S_CUT_RD;
			end
			S_FINISH: begin
				if (rsp_free) begin
					done    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOP;
			idx_q   <= '0;
			count_q <= '0;
			high_q  <= '0;
			full_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						phase_q <= PH_TOP;
						idx_q   <= '0;
						full_q  <= 1'b0;
					end
				end
				S_ADD_COMMIT: begin
					if (!smap_st.found) begin
						full_q <= 1'b1;
					end else begin
						if (CNT_W'(smap_st.idx) >= count_q) begin
							count_q <= CNT_W'(smap_st.idx) + CNT_W'(1);
						end
						if (new_end > high_q) begin
							high_q <= new_end;
						end
					end
				end
				S_CUT_DEC: begin
					if (cs_q < ce_q && cs_q > rs_q) begin
						phase_q <= PH_LEFT;
					end
				end
				S_CUT_RIGHT: begin
					if (ce_q < re_q) begin
						phase_q <= PH_RIGHT;
					end
				end
				S_CUT_NEXT: begin
					idx_q <= idx_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					lo_q         <= page_down(req_data.region_start);
					hi_q         <= page_up(req_data.cut_end);
					pend_start_q <= req_data.region_start;
					pend_len_q   <= req_data.region_length;
				end
			end
			S_ADD_PREP: begin
				s_q <= page_up(pend_start_q);
				l_q <= page_down(pend_len_q);
			end
			S_CUT_RE: begin
				rs_q <= rd_slot.start;
				re_q <= rd_slot.start + rd_slot.length;
			end
			S_CUT_CLIP: begin
				cs_q <= (lo_q < rs_q) ? rs_q : lo_q;
				ce_q <= (hi_q > re_q) ? re_q : hi_q;
			end
			S_CUT_DEC: begin
				pend_start_q <= rs_q;
				pend_len_q   <= cs_q - rs_q;
			end
			S_CUT_RIGHT: begin
				pend_start_q <= ce_q;
				pend_len_q   <= re_q - ce_q;
			end
			default: begin
			end
		endcase
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("slot RAM read and written in the same cycle");

	a_read_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (state_q == S_CUT_RE))
		else $error("slot read data not consumed in the following cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("slot count beyond table size");

	a_full_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD_COMMIT && !smap_st.found) |=> (full_q && state_q == S_FINISH))
		else $error("failed insertion did not abandon the request");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("slot count decreased");
endmodule

FILE: test/memory_region_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for memory_region_table: directed and random add and cut
// requests, each response checked against an in-bench model of the region table.
// Depends on memory_region_table, mrt_pkg, mrt_req_if and mrt_rsp_if from the design folder.
module memory_region_table_tb;
	import mrt_pkg::*;

	localparam int          RAND_REQS  = 1700;
	localparam int          CYCLE_CAP  = 1_500_000;
	localparam int          TAIL_REQS  = 150;   // final stretch runs without idling
	localparam int          HOLD_AT    = 300;   // request count that starts the long hold-off
	localparam int          HOLD_LEN   = 400;
	localparam int          DRAIN_WAIT = 200;
	localparam logic [31:0] WIN_BASE   = 32'h0100_0000;
	localparam logic [31:0] PG         = 32'h0000_1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mrt_req_if req_ch ();
	mrt_rsp_if rsp_ch ();

	memory_region_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// In-bench copy of the region table.
	logic [31:0] tbl_start [MAX_ENTRIES];
	logic [31:0] tbl_len [MAX_ENTRIES];
	int          tbl_used;
	logic [31:0] tbl_top;

	req_t req_backlog [$];
	rsp_t due_rsps [$];

	int  total_reqs;
	int  n_sent, n_rsp, n_add, n_cut, n_full, n_err;
	int  cycles;
	bit  req_taken, offering;
	int  send_gap, stall_cnt, hold_cnt;
	bit  hold_done;

	function automatic logic [31:0] align_down(input logic [31:0] v);
		return v & ~(PG - 32'd1);
	endfunction

	// Rounds up to the next page; wraps to zero above the last page.
	function automatic logic [31:0] align_up(input logic [31:0] v);
		if (v[11:0] == 12'd0) begin
			return v;
		end
		return (v | (PG - 32'd1)) + 32'd1;
	endfunction

	// Writes a rounded region into the lowest free slot; returns 1 when none is free.
	function automatic bit insert_region(input logic [31:0] start, input logic [31:0] len);
		logic [31:0] s, l, e;
		if (len == 32'd0) begin
			return 1'b0;
		end
		s = align_up(start);
		l = align_down(len);
		e = s + l;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (tbl_len[i] != 32'd0) begin
				continue;
			end
			tbl_start[i] = s;
			tbl_len[i] = l;
			if (i >= tbl_used) begin
				tbl_used = i + 1;
			end
			if (e > tbl_top) begin
				tbl_top = e;
			end
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Removes [start, stop) rounded outward from every region it overlaps. The bound of
	// the walk is re-read each step, so slots filled by a remainder are visited too.
	function automatic bit cut_range(input logic [31:0] start, input logic [31:0] stop);
		logic [31:0] lo, hi, rs, re, cs, ce;
		lo = align_down(start);
		hi = align_up(stop);
		for (int i = 0; i < tbl_used && i < MAX_ENTRIES; i++) begin
			rs = tbl_start[i];
			re = rs + tbl_len[i];
			cs = (lo < rs) ? rs : lo;
			ce = (hi > re) ? re : hi;
			if (cs >= ce) begin
				continue;
			end
			tbl_start[i] = 32'd0;
			tbl_len[i] = 32'd0;
			if (cs > rs && insert_region(rs, cs - rs)) begin
				return 1'b1;
			end
			if (ce < re && insert_region(ce, re - ce)) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic rsp_t apply_request(input req_t r);
		rsp_t o;
		bit   full;
		if (r.opcode == OP_ADD) begin
			full = insert_region(r.region_start, r.region_length);
		end else begin
			full = cut_range(r.region_start, r.cut_end);
		end
		o.status = full ? STAT_FULL : STAT_OK;
		o.entries_used = tbl_used[ENT_W-1:0];
		o.high_mark = tbl_top;
		return o;
	endfunction

	task automatic queue_req(input logic op, input logic [31:0] start,
			input logic [31:0] len, input logic [31:0] stop);
		req_t r;
		r.opcode = op;
		r.region_start = start;
		r.region_length = len;
		r.cut_end = stop;
		req_backlog.push_back(r);
	endtask

	// Idling comes in phases of none, light and heavy, and stops near the end.
	function automatic bit idle_roll();
		if (n_sent >= total_reqs - TAIL_REQS) begin
			return 1'b0;
		end
		case ((n_sent / 128) % 3)
			0: return 1'b0;
			1: return ($urandom_range(0, 9) == 0);
			default: return ($urandom_range(0, 2) == 0);
		endcase
	endfunction

	// Request driver: holds each request until it is taken, with random gaps between.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken) begin
				req_backlog.delete(0);
				req_taken = 1'b0;
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (req_backlog.size() > 0) begin
					if (idle_roll()) begin
						send_gap = $urandom_range(0, 8);
					end else begin
						offering = 1'b1;
					end
				end
			end
			req_ch.valid <= offering;
			if (offering) begin
				req_ch.data <= req_backlog[0];
			end
		end
	end

	// Response receiver: random stall bursts plus one long hold-off that backs up the block.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && n_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_LEN - 1;
				rsp_ch.ready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_roll()) begin
				stall_cnt = $urandom_range(0, 8);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on each accepted request and checks each accepted response.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				req_taken = 1'b1;
				n_sent++;
				if (req_ch.data.opcode == OP_ADD) begin
					n_add++;
				end else begin
					n_cut++;
				end
				due_rsps.push_back(apply_request(req_ch.data));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_rsp++;
				if (due_rsps.size() == 0) begin
					n_err++;
					if (n_err <= 10) begin
						$display("ERROR: response %0d arrived with nothing outstanding", n_rsp);
					end
				end else begin
					exp_rsp = due_rsps.pop_front();
					if (exp_rsp.status == STAT_FULL) begin
						n_full++;
					end
					if (rsp_ch.data.status !== exp_rsp.status ||
							rsp_ch.data.entries_used !== exp_rsp.entries_used ||
							rsp_ch.data.high_mark !== exp_rsp.high_mark) begin
						n_err++;
						if (n_err <= 10) begin
							$display("ERROR: response %0d expected status %0b used %0d mark 0x%08h,",
								n_rsp, exp_rsp.status, exp_rsp.entries_used, exp_rsp.high_mark);
							$display("       got status %0b used %0d mark 0x%08h",
								rsp_ch.data.status, rsp_ch.data.entries_used,
								rsp_ch.data.high_mark);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Timeout after %0d cycles with %0d responses still due",
				cycles, due_rsps.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] s, a;
		int          pick;

		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			tbl_start[i] = 32'd0;
			tbl_len[i] = 32'd0;
		end
		tbl_used = 0;
		tbl_top = 32'd0;

		// Directed part: rounding corners, wraps, extremes and a full table.
		queue_req(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF); // zero length
		queue_req(OP_ADD, 32'h0000_1001, 32'h0000_0800, 32'h0000_0000); // rounds to nothing
		queue_req(OP_ADD, 32'hFFFF_F001, 32'h0000_3000, 32'h0000_0000); // start wraps to zero
		queue_req(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000); // largest length
		queue_req(OP_CUT, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_F001); // end wraps, empty
		queue_req(OP_CUT, 32'h0000_5000, 32'hFFFF_FFFF, 32'h0000_6000); // split in two
		queue_req(OP_CUT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_F000); // clear all
		queue_req(OP_ADD, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_0000); // end wraps past zero
		for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
			queue_req(OP_ADD, 32'h0020_0000 + i * 32'h0001_0000, 32'h0000_4000, 32'h0);
		end
		queue_req(OP_ADD, 32'h0080_0000, 32'h0000_2000, 32'h0000_0000); // no free slot
		queue_req(OP_CUT, 32'h0021_1000, 32'h0000_0000, 32'h0021_2000); // right piece lost
		queue_req(OP_CUT, 32'h0000_0FFF, 32'h0000_0000, 32'hFFFF_E001); // clear all but the region that wraps past zero

		// Random part: mostly overlapping traffic inside a small window of pages.
		for (int k = 0; k < RAND_REQS; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				s = WIN_BASE + $urandom_range(0, 255) * PG;
				if ($urandom_range(0, 3) == 0) begin
					s = s + $urandom_range(1, 4095);
				end
				a = $urandom_range(1, 24) * PG + ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
				queue_req(OP_ADD, s, a, $urandom);
			end else if (pick < 53) begin
				// Anywhere in the address space, but never past the last page.
				s = $urandom;
				a = $urandom_range(0, 32'hFFFF_F000 - align_up(s));
				queue_req(OP_ADD, s, a, $urandom);
			end else if (pick < 56) begin
				queue_req(OP_ADD, $urandom, $urandom_range(0, 4095), $urandom);
			end else if (pick < 87) begin
				s = WIN_BASE + $urandom_range(0, 255) * PG;
				if ($urandom_range(0, 1)) begin
					s = s + $urandom_range(0, 4095);
				end
				if ($urandom_range(0, 9) == 0) begin
					a = s - $urandom_range(0, 8) * PG;
				end else begin
					a = s + $urandom_range(0, 40) * PG + $urandom_range(0, 4095);
				end
				queue_req(OP_CUT, s, $urandom, a);
			end else if (pick < 97) begin
				queue_req(OP_CUT, $urandom, $urandom, $urandom);
			end else begin
				queue_req(OP_CUT, $urandom_range(0, 4095), $urandom,
					32'hFFFF_F000 - $urandom_range(0, 4095));
			end
		end
		total_reqs = req_backlog.size();

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (!(n_sent == total_reqs && due_rsps.size() == 0)) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d requests (%0d adds, %0d cuts) with idling and a long output hold-off;",
			n_sent, n_add, n_cut);
		$display("%0d responses reported a full table, %0d mismatches, final mark 0x%08h",
			n_full, n_err, tbl_top);
		if (n_err == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
